FILE: hdl/hbpe_pkg.sv
// hbpe_pkg: shared constants, function codes and controller/datapath interface
// structs for the huffman bit-pack encoder
// no dependencies
`timescale 1ns / 1ps

package hbpe_pkg;

    localparam int SYMBOLS      = 128;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W  = 7;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;
    localparam int ROOM_W = 4;
    localparam int IDX_W  = $clog2(SYMBOLS);
    localparam int ENTRY_W = CODE_W + LEN_W;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // input word layout
    localparam int IN_SYM_LO  = 0;
    localparam int IN_CODE_LO = IN_SYM_LO + SYM_W;
    localparam int IN_LEN_LO  = IN_CODE_LO + CODE_W;
    localparam int IN_USED_W  = IN_LEN_LO + LEN_W;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int FUNC_W     = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

    typedef struct packed {
        logic wr_en;       // table write
        logic rd_en;       // table lookup
        logic load_code;   // move looked-up code into shifter
        logic step;        // one packing step
        logic emit_err;    // missing entry word
        logic emit_flush;  // padded last word
    } cmd_t;

    typedef struct packed {
        logic hit;         // looked-up entry is valid
        logic last_step;   // remaining code bits fit the pending byte
        logic pend_empty;  // no pending bits
        logic out_free;    // output register can take a word this cycle
    } sts_t;

endpackage

FILE: hdl/hbpe_datapath.sv
// hbpe_datapath: code table memory with valid bits, code shifter, pending byte
// and output register
// depends on hbpe_pkg
`timescale 1ns / 1ps

module hbpe_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hbpe_pkg::cmd_t                cmd,
    output hbpe_pkg::sts_t                sts,
    input  logic [hbpe_pkg::SYM_W-1:0]    symbol,
    input  logic [hbpe_pkg::CODE_W-1:0]   code_bits,
    input  logic [hbpe_pkg::LEN_W-1:0]    code_len,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [hbpe_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last,
    output logic                          out_status
);

    logic [hbpe_pkg::ENTRY_W-1:0] mem [hbpe_pkg::SYMBOLS];
    logic [hbpe_pkg::SYMBOLS-1:0] valid_reg, valid_next;
    logic [hbpe_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                         hit_reg, hit_next;

    logic [hbpe_pkg::CODE_W-1:0]  code_reg, code_next;
    logic [hbpe_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic [hbpe_pkg::BYTE_W-1:0]  pend_reg, pend_next;
    logic [hbpe_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [hbpe_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_status_reg, out_status_next;

    logic                         in_range;
    logic [hbpe_pkg::IDX_W-1:0]   idx;
    logic [hbpe_pkg::LEN_W-1:0]   len_sat;
    logic [hbpe_pkg::CODE_W-1:0]  rd_code;
    logic [hbpe_pkg::LEN_W-1:0]   rd_len;
    logic [hbpe_pkg::LEN_W-1:0]   just_amt;
    logic [hbpe_pkg::ROOM_W-1:0]  room;
    logic [hbpe_pkg::ROOM_W-1:0]  take;
    logic [hbpe_pkg::ROOM_W-1:0]  fill;
    logic [2*hbpe_pkg::BYTE_W-1:0] merged;
    logic                         complete;
    logic                         emit_byte;

    assign idx      = symbol[hbpe_pkg::IDX_W-1:0];
    assign in_range = (32'(symbol) < hbpe_pkg::SYMBOLS);
    assign len_sat  = (code_len > hbpe_pkg::LEN_W'(hbpe_pkg::LEN_LIMIT))
                      ? hbpe_pkg::LEN_W'(hbpe_pkg::LEN_LIMIT) : code_len;

    assign rd_code  = rd_data_reg[hbpe_pkg::CODE_W-1:0];
    assign rd_len   = rd_data_reg[hbpe_pkg::ENTRY_W-1:hbpe_pkg::CODE_W];
    // left-justify so the first code bit sits at the msb
    assign just_amt = hbpe_pkg::LEN_W'(hbpe_pkg::CODE_W) - rd_len;

    assign room = hbpe_pkg::ROOM_W'(hbpe_pkg::BYTE_W) - {1'b0, cnt_reg};
    assign take = (rem_reg < hbpe_pkg::LEN_W'(room)) ? hbpe_pkg::ROOM_W'(rem_reg) : room;
    assign fill = {1'b0, cnt_reg} + take;
    assign complete = (fill == hbpe_pkg::ROOM_W'(hbpe_pkg::BYTE_W));
    assign merged = {pend_reg, code_reg[hbpe_pkg::CODE_W-1 -: hbpe_pkg::BYTE_W]} << take;
    assign emit_byte = cmd.step && complete;

    assign sts.hit        = hit_reg;
    assign sts.last_step  = (rem_reg <= hbpe_pkg::LEN_W'(room));
    assign sts.pend_empty = (cnt_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && in_range)
        begin
            mem[idx] <= {len_sat, code_bits};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (cmd.wr_en && in_range)
        begin
            valid_next[idx] = 1'b1;
        end
        if (cmd.rd_en)
        begin
            hit_next = valid_reg[idx] && in_range;
        end
    end

    always_comb
    begin
        code_next = code_reg;
        rem_next  = rem_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        if (cmd.load_code)
        begin
            code_next = rd_code << just_amt;
            rem_next  = rd_len;
        end
        else if (cmd.step)
        begin
            code_next = code_reg << take;
            rem_next  = rem_reg - hbpe_pkg::LEN_W'(take);
            pend_next = complete ? '0 : merged[2*hbpe_pkg::BYTE_W-1:hbpe_pkg::BYTE_W];
            cnt_next  = fill[hbpe_pkg::CNT_W-1:0];
        end
        else if (cmd.emit_flush)
        begin
            pend_next = '0;
            cnt_next  = '0;
        end
    end

    always_comb
    begin
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        if (emit_byte)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = merged[2*hbpe_pkg::BYTE_W-1:hbpe_pkg::BYTE_W];
            out_last_next   = 1'b0;
            out_status_next = 1'b0;
        end
        else if (cmd.emit_err)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = '0;
            out_last_next   = 1'b0;
            out_status_next = 1'b1;
        end
        else if (cmd.emit_flush)
        begin
            out_valid_next  = 1'b1;
            // pad with zeros at the low end
            out_byte_next   = pend_reg << room;
            out_last_next   = 1'b1;
            out_status_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_reg       <= 1'b0;
            rem_reg       <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            hit_reg       <= hit_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

endmodule

FILE: hdl/hbpe_ctrl.sv
// hbpe_ctrl: state machine sequencing table load, lookup, packing and flush
// depends on hbpe_pkg
`timescale 1ns / 1ps

module hbpe_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hbpe_pkg::FUNC_W-1:0]   func,
    input  hbpe_pkg::sts_t                sts,
    output hbpe_pkg::cmd_t                cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FLUSH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        hbpe_pkg::FUNC_LOAD:
                        begin
                            cmd.wr_en = 1'b1;
                        end
                        hbpe_pkg::FUNC_ENCODE:
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_LOOKUP;
                        end
                        hbpe_pkg::FUNC_FLUSH:
                        begin
                            state_next = S_FLUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (sts.hit)
                begin
                    cmd.load_code = 1'b1;
                    state_next    = S_SHIFT;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // a step may complete a byte, so wait for a free output slot
                if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.last_step)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.pend_empty)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/huffman_bit_pack_encoder.sv
// huffman_bit_pack_encoder: top level, joins the controller and the datapath
// depends on hbpe_pkg, hbpe_ctrl, hbpe_datapath
`timescale 1ns / 1ps

// usage
// input words on s_*: s_tuser selects load, encode or flush; s_tdata carries
// the symbol, code bits and code length. output words on m_*: m_tdata is a
// packed byte (earliest bit in bit 7), m_tlast marks the padded flush byte,
// m_tuser flags an encode of a symbol that has no table entry.
// a load is done on acceptance. an encode does a table lookup, loads the
// code into the shifter, then packs it in steps of at most 8 bits each; a
// zero-length code still takes one step. a flush goes through its own state
// before emitting. each output word appears in the cycle after its step.
// the next word is taken once the current one is done, while a finished
// output word may still wait in the output register.
// reset clears the table valid bits, the pending byte and the output
// register at once; the block is ready in the first cycle after reset.
// when m_tready is low and the output register holds a word, each packing
// step waits, and s_tready stays low until the current word is finished.

module huffman_bit_pack_encoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // symbol[6:0], code_bits[38:7], code_len[44:39], zero pad above
    input  logic [hbpe_pkg::IN_DATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [hbpe_pkg::FUNC_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_byte[7:0]
    output logic [hbpe_pkg::BYTE_W-1:0]       m_tdata,
    output logic                              m_tlast,
    // status[0]
    output logic [0:0]                        m_tuser
);

    hbpe_pkg::cmd_t cmd;
    hbpe_pkg::sts_t sts;
    logic           out_status;

    hbpe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .func     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    hbpe_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .symbol     (s_tdata[hbpe_pkg::IN_SYM_LO +: hbpe_pkg::SYM_W]),
        .code_bits  (s_tdata[hbpe_pkg::IN_CODE_LO +: hbpe_pkg::CODE_W]),
        .code_len   (s_tdata[hbpe_pkg::IN_LEN_LO +: hbpe_pkg::LEN_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_status (out_status)
    );

    assign m_tuser[0] = out_status;

endmodule

FILE: hdl/hbpe_checker.sv
// hbpe_checker: port-level assertions for the huffman bit-pack encoder,
// bound to the top level
// depends on hbpe_pkg, huffman_bit_pack_encoder
`timescale 1ns / 1ps

module hbpe_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [hbpe_pkg::FUNC_W-1:0]       s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [hbpe_pkg::BYTE_W-1:0]       m_tdata,
    input  logic                              m_tlast,
    input  logic [0:0]                        m_tuser
);

    // a stalled output word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // missing entry word is all zero and never last
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tlast)
        else $error("malformed missing entry word");

    // an encode word keeps the input side busy for the lookup
    a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == hbpe_pkg::FUNC_ENCODE) |=> !s_tready)
        else $error("input taken during lookup");

    // a load word leaves the input side ready for the next word
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == hbpe_pkg::FUNC_LOAD) |=> s_tready)
        else $error("table load did not finish in one cycle");

endmodule

bind huffman_bit_pack_encoder hbpe_checker u_hbpe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: tb/testbench.sv
// testbench for huffman_bit_pack_encoder: directed table, then random loads,
// encodes and flushes, each byte checked against the directed row or an in-bench packing predictor
// depends on hbpe_pkg and the huffman_bit_pack_encoder rtl
`timescale 1ns / 1ps

module testbench;

    localparam logic [hbpe_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 250;
    localparam int DIRECTED_ROWS = 27;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [hbpe_pkg::BYTE_W-1:0] out_byte;
        logic                        last;
        logic                        status;
    } pack_word_t;

    // typed rows carry n identical expected words instead of the predictor's
    typedef struct packed {
        logic [hbpe_pkg::FUNC_W-1:0] fn;
        logic [hbpe_pkg::SYM_W-1:0]  sym;
        logic [hbpe_pkg::CODE_W-1:0] bits;
        logic [hbpe_pkg::LEN_W-1:0]  len;
        logic                        typed;
        logic [2:0]                  n;
        logic [hbpe_pkg::BYTE_W-1:0] ob;
        logic                        lst;
        logic                        st;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [hbpe_pkg::IN_DATA_W-1:0] s_tdata;
    logic [hbpe_pkg::FUNC_W-1:0]    s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [hbpe_pkg::BYTE_W-1:0]    m_tdata;
    logic                           m_tlast;
    logic [0:0]                     m_tuser;

    huffman_bit_pack_encoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // predictor state
    logic [hbpe_pkg::CODE_W-1:0] code_tab [hbpe_pkg::SYMBOLS];
    logic [hbpe_pkg::LEN_W-1:0]  len_tab  [hbpe_pkg::SYMBOLS];
    logic                        hit_tab  [hbpe_pkg::SYMBOLS];
    logic [hbpe_pkg::BYTE_W-1:0] pend_byte;
    int                          pend_cnt;

    pack_word_t step_words[$];
    pack_word_t expected_words[$];

    int fails;
    int items_sent;
    int words_seen;
    int miss_words;
    int last_words;

    stim_row_t plan [DIRECTED_ROWS] = '{
        // missing entry right after reset, empty flush, unused func
        '{hbpe_pkg::FUNC_ENCODE, 7'd5,   32'h0,        6'd0,  1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
        '{hbpe_pkg::FUNC_FLUSH,  7'd0,   32'h0,        6'd0,  1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{FUNC_UNUSED,           7'd127, 32'hFFFFFFFF, 6'd63, 1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        // full-length all-ones code
        '{hbpe_pkg::FUNC_LOAD,   7'd0,   32'hFFFFFFFF, 6'd32, 1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd0,   32'h0,        6'd0,  1'b1, 3'd4, 8'hFF, 1'b0, 1'b0},
        // zero-length entry on the top symbol
        '{hbpe_pkg::FUNC_LOAD,   7'd127, 32'h0,        6'd0,  1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd127, 32'h0,        6'd0,  1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_LOAD,   7'd1,   32'h5,        6'd3,  1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd1,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_FLUSH,  7'd0,   32'h0,        6'd0,  1'b1, 3'd1, 8'hA0, 1'b1, 1'b0},
        // overlong length saturates
        '{hbpe_pkg::FUNC_LOAD,   7'd2,   32'hFFFFFFFF, 6'd63, 1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd2,   32'h0,        6'd0,  1'b1, 3'd4, 8'hFF, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_LOAD,   7'd3,   32'h1,        6'd1,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd3,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd1,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_LOAD,   7'd4,   32'hA5A5A5A5, 6'd33, 1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd4,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        // missing entry with bits pending, they must survive
        '{hbpe_pkg::FUNC_ENCODE, 7'd100, 32'h0,        6'd0,  1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
        '{hbpe_pkg::FUNC_FLUSH,  7'd0,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_FLUSH,  7'd0,   32'h0,        6'd0,  1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_LOAD,   7'd64,  32'h0,        6'd32, 1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd64,  32'h0,        6'd0,  1'b1, 3'd4, 8'h00, 1'b0, 1'b0},
        // overwrite an entry
        '{hbpe_pkg::FUNC_LOAD,   7'd1,   32'h3,        6'd2,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd1,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_ENCODE, 7'd3,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0},
        '{FUNC_UNUSED,           7'd9,   32'h12345678, 6'd7,  1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
        '{hbpe_pkg::FUNC_FLUSH,  7'd0,   32'h0,        6'd0,  1'b0, 3'd0, 8'h00, 1'b0, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // no idling in every third stretch of 32
    function automatic int idle_draw(input int idx);
        if ((idx / 32) % 3 == 2)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic pack_step(input stim_row_t row);
        int i;
        logic b;
        step_words.delete();
        case (row.fn)
            hbpe_pkg::FUNC_LOAD:
            begin
                code_tab[row.sym] = row.bits;
                len_tab[row.sym]  = (row.len > hbpe_pkg::LEN_LIMIT)
                                    ? hbpe_pkg::LEN_W'(hbpe_pkg::LEN_LIMIT) : row.len;
                hit_tab[row.sym]  = 1'b1;
            end
            hbpe_pkg::FUNC_ENCODE:
            begin
                if (!hit_tab[row.sym])
                    step_words.insert(step_words.size(), pack_word_t'{8'h00, 1'b0, 1'b1});
                else
                begin
                    for (i = int'(len_tab[row.sym]); i > 0; i--)
                    begin
                        b = code_tab[row.sym][i-1];
                        pend_byte = {pend_byte[hbpe_pkg::BYTE_W-2:0], b};
                        pend_cnt++;
                        if (pend_cnt == hbpe_pkg::BYTE_W)
                        begin
                            step_words.insert(step_words.size(),
                                              pack_word_t'{pend_byte, 1'b0, 1'b0});
                            pend_byte = '0;
                            pend_cnt  = 0;
                        end
                    end
                end
            end
            hbpe_pkg::FUNC_FLUSH:
            begin
                if (pend_cnt != 0)
                    step_words.insert(step_words.size(), pack_word_t'{
                        hbpe_pkg::BYTE_W'(pend_byte << (hbpe_pkg::BYTE_W - pend_cnt)),
                        1'b1, 1'b0});
                pend_byte = '0;
                pend_cnt  = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_word(input stim_row_t row);
        int gap;
        int i;
        gap = idle_draw(items_sent);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = row.fn;
        s_tdata  = hbpe_pkg::IN_DATA_W'({row.len, row.bits, row.sym});
        do @(posedge clk); while (!s_tready);
        items_sent++;
        pack_step(row);
        if (row.typed)
        begin
            for (i = 0; i < int'(row.n); i++)
                expected_words.insert(expected_words.size(),
                                      pack_word_t'{row.ob, row.lst, row.st});
        end
        else
        begin
            foreach (step_words[k])
                expected_words.insert(expected_words.size(), step_words[k]);
        end
    endtask

    // receiver: random stalls per word, one long hold-off to back up the block
    initial
    begin
        int stall;
        bit held;
        pack_word_t exp_w;
        m_tready = 1'b0;
        held     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_draw(words_seen);
            if (words_seen == 40 && !held)
            begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            words_seen++;
            if (m_tuser[0])
                miss_words++;
            if (m_tlast)
                last_words++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_byte %h last %b status %b",
                       m_tdata, m_tlast, m_tuser[0]);
                fails++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (m_tdata !== exp_w.out_byte)
                begin
                    $error("out_byte expected %h got %h", exp_w.out_byte, m_tdata);
                    fails++;
                end
                if (m_tlast !== exp_w.last)
                begin
                    $error("last expected %b got %b", exp_w.last, m_tlast);
                    fails++;
                end
                if (m_tuser[0] !== exp_w.status)
                begin
                    $error("status expected %b got %b", exp_w.status, m_tuser[0]);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        int useful;
        int pick;
        int lsel;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = hbpe_pkg::FUNC_LOAD;
        fails      = 0;
        items_sent = 0;
        words_seen = 0;
        miss_words = 0;
        last_words = 0;
        pend_byte  = '0;
        pend_cnt   = 0;
        foreach (hit_tab[i])
        begin
            hit_tab[i]  = 1'b0;
            code_tab[i] = '0;
            len_tab[i]  = '0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            send_word(plan[i]);

        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            lsel = $urandom_range(0, 19);
            row       = '0;
            // mostly a small working set so encodes find their entries
            row.sym   = ($urandom_range(0, 3) == 0)
                        ? hbpe_pkg::SYM_W'($urandom_range(0, 127))
                        : hbpe_pkg::SYM_W'($urandom_range(0, 15));
            row.bits  = $urandom;
            if (lsel == 0)
                row.len = '0;
            else if (lsel == 1)
                row.len = 6'd32;
            else if (lsel == 2)
                row.len = hbpe_pkg::LEN_W'($urandom_range(33, 63));
            else
                row.len = hbpe_pkg::LEN_W'($urandom_range(1, 12));
            if (pick < 20)
                row.fn = hbpe_pkg::FUNC_LOAD;
            else if (pick < 82)
                row.fn = hbpe_pkg::FUNC_ENCODE;
            else if (pick < 96)
                row.fn = hbpe_pkg::FUNC_FLUSH;
            else
                row.fn = FUNC_UNUSED;
            send_word(row);
            if (row.fn != FUNC_UNUSED)
                useful++;
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d words sent, %0d bytes received (%0d missing-entry, %0d flush)",
                 items_sent, words_seen, miss_words, last_words);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
hdl/hbpe_pkg.sv
hdl/hbpe_datapath.sv
hdl/hbpe_ctrl.sv
hdl/huffman_bit_pack_encoder.sv
hdl/hbpe_checker.sv
tb/testbench.sv
